[sv/sdsw_pkg.sv]
// constants, types and the control program of the seven-segment writer
package sdsw_pkg;

    localparam int DISPLAY_COUNT = 8;
    localparam int POS_W = $clog2(DISPLAY_COUNT + 1);
    localparam int VALUE_W = 32;
    localparam int DP_W = 3;
    localparam int CODE_W = 8;
    localparam int OUT_POS_W = 3;
    localparam int PROD_W = 2 * VALUE_W;
    localparam int RECIP_SHIFT = 35;

    // ceil(2^35 / 10), exact quotient for every 32-bit dividend
    localparam logic [VALUE_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
    localparam logic [CODE_W-1:0] MINUS_CODE = 8'd2;
    localparam logic [CODE_W-1:0] BLANK_CODE = 8'd0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIGIT,
        S_SIGN,
        S_MINUS,
        S_FILL,
        S_BLANK
    } step_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL,
        OP_DIGIT,
        OP_MINUS,
        OP_BLANK
    } op_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_IN_VALID,
        C_MORE_DIGITS,
        C_NEG,
        C_POS_END
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t taken;
        step_t fall;
    } uword_t;

    function automatic uword_t ucode(input step_t step);
        uword_t w;
        case (step)
            S_IDLE:  w = '{OP_LOAD,  C_IN_VALID,    S_MUL,   S_IDLE};
            S_MUL:   w = '{OP_MUL,   C_ALWAYS,      S_DIGIT, S_DIGIT};
            S_DIGIT: w = '{OP_DIGIT, C_MORE_DIGITS, S_MUL,   S_SIGN};
            S_SIGN:  w = '{OP_NONE,  C_NEG,         S_MINUS, S_FILL};
            S_MINUS: w = '{OP_MINUS, C_ALWAYS,      S_FILL,  S_FILL};
            S_FILL:  w = '{OP_NONE,  C_POS_END,     S_IDLE,  S_BLANK};
            S_BLANK: w = '{OP_BLANK, C_ALWAYS,      S_FILL,  S_FILL};
            default: w = '{OP_NONE,  C_ALWAYS,      S_IDLE,  S_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [CODE_W-1:0] seg_code(input logic [3:0] digit);
        logic [CODE_W-1:0] c;
        case (digit)
            4'd0:    c = 8'd252;
            4'd1:    c = 8'd96;
            4'd2:    c = 8'd218;
            4'd3:    c = 8'd242;
            4'd4:    c = 8'd102;
            4'd5:    c = 8'd182;
            4'd6:    c = 8'd190;
            4'd7:    c = 8'd224;
            4'd8:    c = 8'd254;
            4'd9:    c = 8'd246;
            default: c = 8'd0;
        endcase
        return c;
    endfunction

endpackage

[sv/signed_decimal_seven_segment_writer.sv]
// signed value to seven-segment display writes, driven by a small control program
//
// s_ channel: one signed scaled value per item in s_tdata.
// m_ channel: one write per display, position 0 (rightmost) first; tlast marks
// the write to the leftmost display. DISPLAY_COUNT writes per input item.
// cfg_we / cfg_wdata set the decimal point position (reset value 1).
// Each digit runs a multiply step (a 32x32 reciprocal multiply for the divide
// by ten), then a digit step for the remainder and the write. Minus has its own
// write step; each blank runs a fill check step, then a blank write step.
// After accept the program runs the multiply step, then the first digit step
// loads the first write into the output register.
// s_tready is high only while the program waits at its idle step, so a new
// item is taken only once the program has gone from the last write of the run
// through the fill check (after a final digit, the sign check first) to idle.
// A stalled sink holds the output register and the program waits at its
// current write step; nothing is dropped.
// aresetn (synchronous, active low) returns the program to idle, empties the
// output register and sets the decimal places to 1.
module signed_decimal_seven_segment_writer
    import sdsw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // scaled_value[31:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // segment_code[7:0], position[10:8], zero fill
    output logic        m_tlast    // last
);

    step_t                 step_reg, step_next;
    logic [DP_W-1:0]       dp_reg, dp_next;
    logic [VALUE_W-1:0]    mag_reg, mag_next;
    logic                  neg_reg, neg_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [CODE_W-1:0]     code_reg, code_next;
    logic [OUT_POS_W-1:0]  opos_reg, opos_next;
    logic                  last_reg, last_next;

    uword_t                uw;
    logic                  out_free;
    logic                  emits;
    logic                  hold;
    logic                  cond_ok;
    logic [VALUE_W-1:0]    quot;
    logic [VALUE_W-1:0]    rem_full;
    logic [3:0]            digit;
    logic [POS_W-1:0]      pos_inc;
    logic [POS_W-1:0]      limit;
    logic [POS_W-1:0]      dp_ext;
    logic                  point;
    logic [CODE_W-1:0]     emit_code;

    assign uw       = ucode(step_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign emits    = (uw.op == OP_DIGIT) || (uw.op == OP_MINUS) || (uw.op == OP_BLANK);
    assign hold     = emits && !out_free;

    assign quot     = VALUE_W'(prod_reg[PROD_W-1:RECIP_SHIFT]);
    assign rem_full = mag_reg - ((quot << 3) + (quot << 1));
    assign digit    = rem_full[3:0];
    assign pos_inc  = pos_reg + POS_W'(1);
    assign limit    = POS_W'(DISPLAY_COUNT) - POS_W'(neg_reg);
    assign dp_ext   = POS_W'(dp_reg);
    assign point    = (pos_reg == dp_ext);

    always_comb begin
        case (uw.op)
            OP_DIGIT: emit_code = seg_code(digit) + CODE_W'(point);
            OP_MINUS: emit_code = MINUS_CODE;
            default:  emit_code = BLANK_CODE;
        endcase
    end

    always_comb begin
        case (uw.cond)
            C_ALWAYS:      cond_ok = 1'b1;
            C_IN_VALID:    cond_ok = s_tvalid;
            C_MORE_DIGITS: cond_ok = (pos_inc < limit) && ((quot != '0) || (pos_inc <= dp_ext));
            C_NEG:         cond_ok = neg_reg;
            C_POS_END:     cond_ok = (pos_reg >= POS_W'(DISPLAY_COUNT));
            default:       cond_ok = 1'b0;
        endcase
    end

    assign s_tready = (uw.op == OP_LOAD);

    always_comb begin
        step_next     = step_reg;
        dp_next       = cfg_we ? cfg_wdata : dp_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        pos_next      = pos_reg;
        prod_next     = prod_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        code_next     = code_reg;
        opos_next     = opos_reg;
        last_next     = last_reg;
        if (!hold) begin
            step_next = cond_ok ? uw.taken : uw.fall;
            case (uw.op)
                OP_LOAD: begin
                    if (s_tvalid) begin
                        neg_next = s_tdata[VALUE_W-1];
                        mag_next = s_tdata[VALUE_W-1] ? (VALUE_W'(0) - s_tdata) : s_tdata;
                        pos_next = '0;
                    end
                end
                OP_MUL: begin
                    prod_next = PROD_W'(mag_reg) * PROD_W'(RECIP_TEN);
                end
                OP_DIGIT, OP_MINUS, OP_BLANK: begin
                    if (uw.op == OP_DIGIT) begin
                        mag_next = quot;
                    end
                    m_tvalid_next = 1'b1;
                    code_next     = emit_code;
                    opos_next     = pos_reg[OUT_POS_W-1:0];
                    last_next     = (pos_reg == POS_W'(DISPLAY_COUNT - 1));
                    pos_next      = pos_inc;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= S_IDLE;
            dp_reg       <= DP_W'(1);
            m_tvalid_reg <= 1'b0;
        end else begin
            step_reg     <= step_next;
            dp_reg       <= dp_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        pos_reg  <= pos_next;
        prod_reg <= prod_next;
        code_reg <= code_next;
        opos_reg <= opos_next;
        last_reg <= last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, opos_reg, code_reg};
    assign m_tlast  = last_reg;

endmodule
